>>> sv/sbus_pkg.sv
package sbus_pkg;

  localparam int FRAME_BYTES = 25;
  localparam int FLAG_BYTE   = 23;
  localparam int IDX_W       = 5;
  localparam int CHAN_W      = 11;
  localparam int COORD_W     = 8;
  localparam int NUM_W       = 19;  // (chan_max - chan_min) * 200 fits here
  localparam int TIMER_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(FRAME_BYTES - 1);

  localparam logic [COORD_W-1:0] COORD_OFFSET = 8'd100;
  localparam logic [TIMER_W-1:0] TIMER_MAX    = 16'hFFFF;

  localparam int SIG_LOST_BIT = 2;
  localparam int FAILSAFE_BIT = 3;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_DELIM = 2'd1,
    STATUS_SIG_LOST  = 2'd2,
    STATUS_FAILSAFE  = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd4;

  localparam logic [7:0]         START_BYTE_RST = 8'd15;
  localparam logic [7:0]         END_BYTE_RST   = 8'd0;
  localparam logic [CHAN_W-1:0]  CHAN_MIN_RST   = 11'd172;
  localparam logic [CHAN_W-1:0]  CHAN_MAX_RST   = 11'd1811;
  localparam logic [TIMER_W-1:0] TIMEOUT_RST    = 16'd2000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_SETUP,
    ST_DIV,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic clamp_en;
    logic setup_en;
    logic div_en;
    logic out_load;
  } ctrl_t;

endpackage

>>> sv/sbus_frame_decoder_top.sv
// Frame decoder for a 25-byte serial servo-bus stream. Each transfer on the input is either a
// received byte (tuser = 0) or one time tick (tuser = 1), and each gives exactly one result
// transfer: the first four channels clamped to [chan_min, chan_max] or zero with the link down,
// the stick coordinates for channels one and two mapped to -100..100, the status of the latest
// frame, the link state, and tlast high when that byte closed a frame. The byte counter wraps
// every 25 bytes and never resyncs. An item passes through a clamp state, then for each
// coordinate a setup state and 8 steps in a single shared restoring divider that computes the
// two coordinates one quotient bit a cycle, and then the output register is loaded. The input is
// ready again in the cycle after the result is loaded, while it still waits to be taken
// downstream, so a new item is taken only once the last one's result is loaded; a stalled
// output holds back the load and with it the next input. Configuration writes go through
// cfg_we/cfg_index/cfg_data and must only be issued while the block is idle.
module sbus_frame_decoder_top #(
  parameter int CHANNELS_OUT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  // [10:0] chan_one, [21:11] chan_two, [32:22] chan_three, [43:33] chan_four,
  // [51:44] coord_x, [59:52] coord_y, [61:60] frame_status, [62] link_alive, [63] zero
  output logic [63:0] m_tdata,
  output logic        m_tlast,   // frame_done
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CW = sbus_pkg::CHAN_W;
  localparam int NW = sbus_pkg::NUM_W;

  // configuration
  logic [7:0]                     start_byte;
  logic [7:0]                     end_byte;
  logic [CW-1:0]                  chan_min;
  logic [CW-1:0]                  chan_max;
  logic [sbus_pkg::TIMER_W-1:0]   timeout_ticks;

  // frame state
  logic [sbus_pkg::IDX_W-1:0]     byte_index;
  logic [7:0]                     first_byte;
  logic [7:0]                     payload [6];
  logic [7:0]                     flag_byte;
  logic [CW-1:0]                  channel_regs [4];
  logic [sbus_pkg::TIMER_W-1:0]   ticks_since_good;
  sbus_pkg::status_t              last_status;
  logic                           done_q;

  // per-item working registers
  logic [CW-1:0]                  chan_res [4];
  logic                           alive_q;
  logic                           map_ok;
  logic                           coord_sel;
  logic [NW-1:0]                  rem;
  logic [NW-1:0]                  dsh;
  logic [7:0]                     quo;
  logic [2:0]                     step_cnt;
  logic [7:0]                     coord_x;
  logic [7:0]                     coord_y;

  sbus_pkg::state_t               state;
  sbus_pkg::state_t               state_next;
  sbus_pkg::ctrl_t                ctrl;

  logic                           out_free;
  sbus_pkg::status_t              close_status;
  logic                           is_byte;
  logic                           closing;
  logic [7:0]                     quo_next;
  logic [NW-1:0]                  rem_next;
  logic [CW-1:0]                  map_chan;
  logic [CW-1:0]                  map_diff;
  logic [CW-1:0]                  range_span;
  logic [NW-1:0]                  numer;
  logic [7:0]                     coord_val;

  assign out_free = !m_tvalid || m_tready;
  assign is_byte  = !s_tuser[0];
  assign closing  = is_byte && (byte_index == sbus_pkg::LAST_INDEX);

  // frame check, with the incoming byte as the end byte
  always_comb begin
    priority if (first_byte != start_byte || s_tdata != end_byte) begin
      close_status = sbus_pkg::STATUS_BAD_DELIM;
    end else if (flag_byte[sbus_pkg::SIG_LOST_BIT]) begin
      close_status = sbus_pkg::STATUS_SIG_LOST;
    end else if (flag_byte[sbus_pkg::FAILSAFE_BIT]) begin
      close_status = sbus_pkg::STATUS_FAILSAFE;
    end else begin
      close_status = sbus_pkg::STATUS_OK;
    end
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      sbus_pkg::ST_IDLE:  if (s_tvalid) state_next = sbus_pkg::ST_CLAMP;
      sbus_pkg::ST_CLAMP: state_next = sbus_pkg::ST_SETUP;
      sbus_pkg::ST_SETUP: state_next = sbus_pkg::ST_DIV;
      sbus_pkg::ST_DIV: begin
        if (step_cnt == 3'd0) begin
          state_next = coord_sel ? sbus_pkg::ST_WAIT : sbus_pkg::ST_SETUP;
        end
      end
      sbus_pkg::ST_WAIT:  if (out_free) state_next = sbus_pkg::ST_IDLE;
      default:            state_next = sbus_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    ctrl     = '0;
    s_tready = 1'b0;
    unique case (state)
      sbus_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        ctrl.accept = s_tvalid;
      end
      sbus_pkg::ST_CLAMP: ctrl.clamp_en = 1'b1;
      sbus_pkg::ST_SETUP: ctrl.setup_en = 1'b1;
      sbus_pkg::ST_DIV:   ctrl.div_en   = 1'b1;
      sbus_pkg::ST_WAIT:  ctrl.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbus_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= sbus_pkg::START_BYTE_RST;
      end_byte      <= sbus_pkg::END_BYTE_RST;
      chan_min      <= sbus_pkg::CHAN_MIN_RST;
      chan_max      <= sbus_pkg::CHAN_MAX_RST;
      timeout_ticks <= sbus_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbus_pkg::REG_START_BYTE: start_byte    <= cfg_data[7:0];
        sbus_pkg::REG_END_BYTE:   end_byte      <= cfg_data[7:0];
        sbus_pkg::REG_CHAN_MIN:   chan_min      <= cfg_data[CW-1:0];
        sbus_pkg::REG_CHAN_MAX:   chan_max      <= cfg_data[CW-1:0];
        sbus_pkg::REG_TIMEOUT:    timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // only the bytes that the decode reads are kept
  always_ff @(posedge clk) begin
    if (ctrl.accept && is_byte) begin
      if (byte_index == '0) first_byte <= s_tdata;
      if (byte_index == sbus_pkg::IDX_W'(sbus_pkg::FLAG_BYTE)) flag_byte <= s_tdata;
      for (int i = 0; i < 6; i++) begin
        if (byte_index == sbus_pkg::IDX_W'(i + 1)) payload[i] <= s_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index       <= '0;
      ticks_since_good <= '0;
      last_status      <= sbus_pkg::STATUS_OK;
      done_q           <= 1'b0;
      for (int j = 0; j < 4; j++) channel_regs[j] <= '0;
    end else if (ctrl.accept) begin
      done_q <= closing;
      if (is_byte) begin
        byte_index <= closing ? '0 : byte_index + 1'b1;
        if (closing) begin
          last_status <= close_status;
          if (close_status == sbus_pkg::STATUS_OK) begin
            ticks_since_good <= '0;
            channel_regs[0]  <= {payload[1][2:0], payload[0]};
            channel_regs[1]  <= {payload[2][5:0], payload[1][7:3]};
            channel_regs[2]  <= {payload[4][0], payload[3], payload[2][7:6]};
            channel_regs[3]  <= {payload[5][3:0], payload[4][7:1]};
          end else begin
            for (int j = 0; j < 4; j++) channel_regs[j] <= '0;
          end
        end
      end else if (ticks_since_good != sbus_pkg::TIMER_MAX) begin
        ticks_since_good <= ticks_since_good + 1'b1;
      end
    end
  end

  // clamp, link state and the gate for the coordinate map
  always_ff @(posedge clk) begin
    if (ctrl.clamp_en) begin
      alive_q <= ticks_since_good < timeout_ticks;
      map_ok  <= (ticks_since_good < timeout_ticks) && (chan_max > chan_min);
      for (int j = 0; j < 4; j++) begin
        if (ticks_since_good >= timeout_ticks) begin
          chan_res[j] <= '0;
        end else if (channel_regs[j] < chan_min) begin
          chan_res[j] <= chan_min;
        end else if (channel_regs[j] > chan_max) begin
          chan_res[j] <= chan_max;
        end else begin
          chan_res[j] <= channel_regs[j];
        end
      end
    end
  end

  // shared restoring divider: (c - chan_min) * 200 / (chan_max - chan_min)
  assign map_chan   = coord_sel ? chan_res[1] : chan_res[0];
  assign map_diff   = map_chan - chan_min;
  assign range_span = chan_max - chan_min;
  assign numer      = {map_diff, 8'd0} - {2'd0, map_diff, 6'd0} + {5'd0, map_diff, 3'd0};

  always_comb begin
    if (rem >= dsh) begin
      rem_next = rem - dsh;
      quo_next = {quo[6:0], 1'b1};
    end else begin
      rem_next = rem;
      quo_next = {quo[6:0], 1'b0};
    end
  end

  assign coord_val = map_ok ? quo_next - sbus_pkg::COORD_OFFSET : 8'd0;

  always_ff @(posedge clk) begin
    if (ctrl.accept) coord_sel <= 1'b0;
    if (ctrl.setup_en) begin
      rem      <= numer;
      dsh      <= {1'b0, range_span, 7'd0};
      quo      <= '0;
      step_cnt <= 3'd7;
    end
    if (ctrl.div_en) begin
      rem      <= rem_next;
      dsh      <= dsh >> 1;
      quo      <= quo_next;
      step_cnt <= step_cnt - 1'b1;
      if (step_cnt == 3'd0) begin
        if (coord_sel) coord_y <= coord_val;
        else           coord_x <= coord_val;
        coord_sel <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      for (int j = 0; j < 4; j++) begin
        m_tdata[j*CW +: CW] <= (j < CHANNELS_OUT) ? chan_res[j] : '0;
      end
      m_tdata[51:44] <= coord_x;
      m_tdata[59:52] <= coord_y;
      m_tdata[61:60] <= last_status;
      m_tdata[62]    <= alive_q;
      m_tdata[63]    <= 1'b0;
      m_tlast        <= done_q;
    end
  end

endmodule

>>> tb/sbus_frame_decoder_checker.sv
module sbus_frame_decoder_checker
  import sbus_pkg::*;
#(
  parameter int CHANNELS_OUT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [3:0][CHAN_W-1:0] chan;
    logic [COORD_W-1:0]     coord_x;
    logic [COORD_W-1:0]     coord_y;
    logic                   done;
    status_t                status;
    logic                   alive;
  } servo_frame_t;

  logic [7:0]         rx_frame [FRAME_BYTES];
  logic [IDX_W-1:0]   fill_pos;
  logic [CHAN_W-1:0]  held_chan [4];
  logic [TIMER_W-1:0] link_ticks;
  status_t            frame_state;

  logic [7:0]         want_start;
  logic [7:0]         want_end;
  logic [CHAN_W-1:0]  lo_limit;
  logic [CHAN_W-1:0]  hi_limit;
  logic [TIMER_W-1:0] link_timeout;

  servo_frame_t decoded_q [$];
  int           mismatch_count = 0;

  assign mismatches = mismatch_count;

  task automatic report_mismatch(string what, longint unsigned got_v, longint unsigned want_v);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got_v, want_v);
    mismatch_count++;
  endtask

  function automatic logic [CHAN_W-1:0] clamp_chan(logic [CHAN_W-1:0] v);
    if (v < lo_limit) return lo_limit;
    if (v > hi_limit) return hi_limit;
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] stick_pos(logic [CHAN_W-1:0] c, logic alive);
    int span;
    int pos;
    if (!alive || hi_limit <= lo_limit || c < lo_limit || c > hi_limit) return '0;
    span = int'(hi_limit) - int'(lo_limit);
    pos  = ((int'(c) - int'(lo_limit)) * 200) / span - 100;
    return pos[COORD_W-1:0];
  endfunction

  function automatic void check_frame();
    logic [7:0] flags;
    flags = rx_frame[FLAG_BYTE];
    // delimiters first, then signal lost over failsafe
    if (rx_frame[0] != want_start || rx_frame[FRAME_BYTES-1] != want_end)
      frame_state = STATUS_BAD_DELIM;
    else if (flags[SIG_LOST_BIT])
      frame_state = STATUS_SIG_LOST;
    else if (flags[FAILSAFE_BIT])
      frame_state = STATUS_FAILSAFE;
    else
      frame_state = STATUS_OK;
    if (frame_state != STATUS_OK) begin
      for (int j = 0; j < 4; j++) held_chan[j] = '0;
    end else begin
      link_ticks   = '0;
      held_chan[0] = {rx_frame[2][2:0], rx_frame[1]};
      held_chan[1] = {rx_frame[3][5:0], rx_frame[2][7:3]};
      held_chan[2] = {rx_frame[5][0], rx_frame[4], rx_frame[3][7:6]};
      held_chan[3] = {rx_frame[6][3:0], rx_frame[5][7:1]};
    end
  endfunction

  function automatic servo_frame_t decode_step(logic is_tick, logic [7:0] rx);
    servo_frame_t      r;
    logic [CHAN_W-1:0] shown [4];
    logic              alive;
    r = '0;
    if (!is_tick) begin
      rx_frame[fill_pos] = rx;
      if (fill_pos == LAST_INDEX) begin
        fill_pos = '0;
        check_frame();
        r.done = 1'b1;
      end else begin
        fill_pos = fill_pos + 1'b1;
      end
    end else if (link_ticks != TIMER_MAX) begin
      link_ticks = link_ticks + 1'b1;
    end
    alive = link_ticks < link_timeout;
    for (int j = 0; j < 4; j++) begin
      shown[j]  = alive ? clamp_chan(held_chan[j]) : '0;
      r.chan[j] = (j < CHANNELS_OUT) ? shown[j] : '0;
    end
    // coordinates follow channels one and two even when they are not output
    r.coord_x = stick_pos(shown[0], alive);
    r.coord_y = stick_pos(shown[1], alive);
    r.status  = frame_state;
    r.alive   = alive;
    return r;
  endfunction

  always @(posedge clk) begin
    servo_frame_t got;
    servo_frame_t want;
    if (rst) begin
      fill_pos     = '0;
      link_ticks   = '0;
      frame_state  = STATUS_OK;
      for (int j = 0; j < 4; j++) held_chan[j] = '0;
      want_start   = START_BYTE_RST;
      want_end     = END_BYTE_RST;
      lo_limit     = CHAN_MIN_RST;
      hi_limit     = CHAN_MAX_RST;
      link_timeout = TIMEOUT_RST;
      decoded_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_BYTE: want_start   = cfg_data[7:0];
          REG_END_BYTE:   want_end     = cfg_data[7:0];
          REG_CHAN_MIN:   lo_limit     = cfg_data[CHAN_W-1:0];
          REG_CHAN_MAX:   hi_limit     = cfg_data[CHAN_W-1:0];
          REG_TIMEOUT:    link_timeout = cfg_data[TIMER_W-1:0];
          default: ;
        endcase
      end
      // retire the output first so a same-edge input transfer cannot cover a stray result
      if (m_tvalid && m_tready) begin
        got.chan    = m_tdata[43:0];
        got.coord_x = m_tdata[51:44];
        got.coord_y = m_tdata[59:52];
        got.status  = status_t'(m_tdata[61:60]);
        got.alive   = m_tdata[62];
        got.done    = m_tlast;
        if (decoded_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", m_tdata, 0);
        end else begin
          want = decoded_q.pop_front();
          for (int j = 0; j < 4; j++)
            if (got.chan[j] !== want.chan[j])
              report_mismatch($sformatf("chan %0d", j + 1), got.chan[j], want.chan[j]);
          if (got.coord_x !== want.coord_x)
            report_mismatch("coord_x", got.coord_x, want.coord_x);
          if (got.coord_y !== want.coord_y)
            report_mismatch("coord_y", got.coord_y, want.coord_y);
          if (got.done !== want.done)
            report_mismatch("frame_done", got.done, want.done);
          if (got.status !== want.status)
            report_mismatch("frame_status", got.status, want.status);
          if (got.alive !== want.alive)
            report_mismatch("link_alive", got.alive, want.alive);
          if (m_tdata[63] !== 1'b0)
            report_mismatch("pad bit", m_tdata[63], 0);
        end
      end
      if (s_tvalid && s_tready)
        decoded_q.push_back(decode_step(s_tuser[0], s_tdata));
      outstanding <= decoded_q.size();
    end
  end

endmodule

>>> tb/sbus_frame_decoder_top_tb.sv
module sbus_frame_decoder_top_tb;
  import sbus_pkg::*;

  localparam int   CHANNELS_OUT  = 4;
  localparam logic OP_BYTE       = 1'b0;
  localparam logic OP_TICK       = 1'b1;
  localparam int   QUIET_LIMIT   = 2000;
  localparam int   SETTLE_CYCLES = 25;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic [0:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  int mismatches;
  int outstanding;

  logic       stall_on  = 1'b0;
  bit         idle_on   = 1'b0;
  int         byte_pos  = 0;
  int         items_sent = 0;
  int         quiet     = 0;
  logic [7:0] cur_start = START_BYTE_RST;
  logic [7:0] cur_end   = END_BYTE_RST;

  sbus_frame_decoder_top #(.CHANNELS_OUT(CHANNELS_OUT)) DUT (.*);

  sbus_frame_decoder_checker #(.CHANNELS_OUT(CHANNELS_OUT)) chk (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) m_tready <= stall_on ? ($urandom_range(0, 99) >= 20) : 1'b1;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_item(logic op, logic [7:0] b);
    if (idle_on && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (op == OP_BYTE) byte_pos = (byte_pos + 1) % FRAME_BYTES;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [7:0] first_b, logic [7:0] last_b,
                                logic [CHAN_W-1:0] lo, logic [CHAN_W-1:0] hi,
                                logic [TIMER_W-1:0] tmo);
    wait_drained();
    write_reg(REG_START_BYTE, 16'(first_b));
    write_reg(REG_END_BYTE, 16'(last_b));
    write_reg(REG_CHAN_MIN, 16'(lo));
    write_reg(REG_CHAN_MAX, 16'(hi));
    write_reg(REG_TIMEOUT, tmo);
    cur_start = first_b;
    cur_end   = last_b;
  endtask

  task automatic send_frame(int tick_burst);
    logic [7:0] bytes_out [FRAME_BYTES];
    int         kind;
    int         fill;
    // a stray byte shifts the framing; the padding then closes a broken frame
    if ($urandom_range(0, 9) == 0) send_item(OP_BYTE, 8'($urandom));
    while (byte_pos != 0) send_item(OP_BYTE, 8'($urandom));
    fill = $urandom_range(0, 3);
    for (int i = 0; i < FRAME_BYTES; i++)
      bytes_out[i] = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
    bytes_out[0]                        = cur_start;
    bytes_out[FRAME_BYTES-1]            = cur_end;
    bytes_out[FLAG_BYTE][SIG_LOST_BIT]  = 1'b0;
    bytes_out[FLAG_BYTE][FAILSAFE_BIT]  = 1'b0;
    kind = $urandom_range(0, 99);
    if (kind >= 55 && kind < 63) bytes_out[FLAG_BYTE][SIG_LOST_BIT] = 1'b1;
    if (kind >= 63 && kind < 71) bytes_out[FLAG_BYTE][FAILSAFE_BIT] = 1'b1;
    if (kind >= 71 && kind < 76) begin
      bytes_out[FLAG_BYTE][SIG_LOST_BIT] = 1'b1;
      bytes_out[FLAG_BYTE][FAILSAFE_BIT] = 1'b1;
    end
    // bad delimiters come with arbitrary flags to exercise the check order
    if (kind >= 76) bytes_out[FLAG_BYTE] = 8'($urandom);
    if ((kind >= 76 && kind < 86) || kind >= 96)
      bytes_out[0] = cur_start ^ 8'($urandom_range(1, 255));
    if (kind >= 86)
      bytes_out[FRAME_BYTES-1] = cur_end ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(OP_TICK, 8'($urandom));
      send_item(OP_BYTE, bytes_out[i]);
    end
    repeat ($urandom_range(0, tick_burst)) send_item(OP_TICK, 8'($urandom));
    if ($urandom_range(0, 49) == 0) wait_drained();
  endtask

  task automatic run_phase(int count, int tick_burst);
    int target;
    target = items_sent + count;
    while (items_sent < target) send_frame(tick_burst);
  endtask

  initial begin
    logic [7:0] first_frame [FRAME_BYTES];
    int         lo;
    repeat (10) @(posedge clk);
    rst      <= 1'b0;
    stall_on <= 1'b1;
    idle_on  = 1'b1;

    // power-up: link alive with empty channels
    repeat (3) send_item(OP_TICK, 8'($urandom));
    for (int i = 0; i < FRAME_BYTES; i++) first_frame[i] = 8'h00;
    first_frame[0] = cur_start;
    first_frame[1] = 8'hFF;
    first_frame[2] = 8'h07;
    first_frame[4] = 8'hFF;
    first_frame[5] = 8'h01;
    first_frame[6] = 8'h0F;
    first_frame[FRAME_BYTES-1] = cur_end;
    for (int i = 0; i < FRAME_BYTES; i++) send_item(OP_BYTE, first_frame[i]);
    repeat (2) send_item(OP_TICK, 8'($urandom));

    apply_settings(8'h0F, 8'h00, 11'd172, 11'd1811, 16'd60);
    run_phase(240, 100);

    // long stretch with both sides streaming
    idle_on  = 1'b0;
    stall_on <= 1'b0;
    apply_settings(8'hFF, 8'hFF, 11'd0, 11'd2047, 16'hFFFF);
    run_phase(240, 8);
    idle_on  = 1'b1;
    stall_on <= 1'b1;

    apply_settings(8'h00, 8'hAA, 11'd1500, 11'd200, 16'd25);
    run_phase(240, 40);
    apply_settings(8'h55, 8'h00, 11'd1000, 11'd1000, 16'd0);
    run_phase(120, 4);
    apply_settings(8'hA5, 8'h5A, 11'd0, 11'd1, 16'd1);
    run_phase(200, 3);
    repeat (3) begin
      lo = $urandom_range(0, 1900);
      apply_settings(8'($urandom), 8'($urandom), 11'(lo),
                     11'($urandom_range(lo + 1, 2047)), 16'($urandom_range(1, 200)));
      run_phase(300, 60);
    end

    wait_drained();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
